// ===== hw/rtl/xxh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh_pkg
// Shared constants, types and helpers of the streaming XXH64 hash block.
// ----------------------------------------------------------------------------
package xxh_pkg;

   localparam logic [63:0] PRIME1 = 64'h9E37_79B1_85EB_CA87;
   localparam logic [63:0] PRIME2 = 64'hC2B2_AE3D_27D4_EB4F;
   localparam logic [63:0] PRIME3 = 64'h1656_67B1_9E37_79F9;
   localparam logic [63:0] PRIME4 = 64'h85EB_CA77_C2B2_AE63;
   localparam logic [63:0] PRIME5 = 64'h27D4_EB2F_1656_67C5;

   // seed-zero lane start values
   localparam logic [63:0] LANE0_INIT = 64'(PRIME1 + PRIME2);
   localparam logic [63:0] LANE1_INIT = PRIME2;
   localparam logic [63:0] LANE2_INIT = 64'd0;
   localparam logic [63:0] LANE3_INIT = 64'(64'd0 - PRIME1);

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_STORE,
      OP_LR_A,
      OP_LR_B,
      OP_STRIPE_END,
      OP_H_INIT,
      OP_H_ROT,
      OP_MG_A,
      OP_MG_B,
      OP_MG_C,
      OP_ADD_LEN,
      OP_TW_A,
      OP_TW_B,
      OP_TW_C,
      OP_Q_A,
      OP_Q_B,
      OP_B_A,
      OP_B_B,
      OP_F1,
      OP_F2,
      OP_OUT
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_STORE,
      ST_LR_A,
      ST_LR_B,
      ST_STRIPE_END,
      ST_H_INIT,
      ST_H_ROT,
      ST_MG_A,
      ST_MG_B,
      ST_MG_C,
      ST_ADD_LEN,
      ST_TW_A,
      ST_TW_B,
      ST_TW_C,
      ST_Q_A,
      ST_Q_B,
      ST_B_A,
      ST_B_B,
      ST_F1,
      ST_F2,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       go;
      op_type     op;
      logic [2:0] idx;
   } cmd_type;

   typedef struct packed {
      logic       done;
      logic       last;
      logic       full;
      logic       had;
      logic [1:0] fill;
      logic [2:0] n;
   } status_type;

   function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
      rotl64 = (x << r) | (x >> (64 - r));
   endfunction

   function automatic logic is_mul_op(input op_type op);
      case (op)
         OP_LR_A, OP_LR_B, OP_MG_A, OP_MG_B, OP_MG_C, OP_TW_A, OP_TW_B, OP_TW_C,
         OP_Q_A, OP_Q_B, OP_B_A, OP_B_B, OP_F1, OP_F2: is_mul_op = 1'b1;
         default: is_mul_op = 1'b0;
      endcase
   endfunction

endpackage

// ===== hw/rtl/xxh_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh_mul
// 64x64 multiplier keeping the low 64 bits, one 32x32 partial product a cycle.
// ----------------------------------------------------------------------------
module xxh_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        done,
   output logic [63:0] p
);
   logic [63:0] a_ff, a_in, b_ff, b_in, acc_ff, acc_in;
   logic [1:0]  step_ff, step_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [31:0] x, y;
   logic [63:0] prod;

   always_comb begin
      // partial products: lo*lo, lo*hi, hi*lo
      x    = (step_ff == 2'd2) ? a_ff[63:32] : a_ff[31:0];
      y    = (step_ff == 2'd1) ? b_ff[63:32] : b_ff[31:0];
      prod = 64'(x) * 64'(y);
      a_in = start ? a : a_ff;
      b_in = start ? b : b_ff;
      acc_in = acc_ff;
      if (busy_ff) begin
         acc_in = (step_ff == 2'd0) ? prod : acc_ff + {prod[31:0], 32'd0};
      end
      done_in = busy_ff && (step_ff == 2'd2);
      busy_in = start ? 1'b1 : (done_in ? 1'b0 : busy_ff);
      step_in = start ? 2'd0 : (busy_ff ? 2'(step_ff + 2'd1) : step_ff);
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   assign done = done_ff;
   assign p    = acc_ff;
endmodule

// ===== hw/rtl/xxh_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh_dp
// Hash datapath: lanes, stripe buffer, length, hash register, shared multiplier.
// ----------------------------------------------------------------------------
module xxh_dp (
   input  logic               clock,
   input  logic               reset,
   input  logic [63:0]        req_word,
   input  logic [3:0]         req_valid_bytes,
   input  logic               req_last,
   input  xxh_pkg::cmd_type    cmd,
   output xxh_pkg::status_type st,
   output logic [63:0]        rsp_hash
);
   import xxh_pkg::*;

   logic [63:0] word_ff, word_in, total_ff, total_in, h_ff, h_in, t_ff, t_in;
   logic [63:0] hash_ff, hash_in;
   logic [63:0] lane_ff [0:3];
   logic [63:0] lane_in [0:3];
   logic [63:0] stripe_ff [0:2];
   logic [63:0] stripe_in [0:2];
   logic [1:0]  fill_ff, fill_in, idx2;
   logic [2:0]  n_ff, n_in;
   logic        last_ff, last_in, full_ff, full_in, had_ff, had_in, busy_ff, busy_in;
   logic [63:0] lane_sel, stripe_sel, lane_rot, mul_a, mul_b, mul_p;
   logic        mul_start, mul_done, op_mul;

   xxh_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .p     (mul_p)
   );

   always_comb begin
      idx2     = cmd.idx[1:0];
      lane_sel = lane_ff[idx2];
      case (idx2)
         2'd0:    stripe_sel = stripe_ff[0];
         2'd1:    stripe_sel = stripe_ff[1];
         2'd2:    stripe_sel = stripe_ff[2];
         default: stripe_sel = word_ff;
      endcase
      case (idx2)
         2'd0:    lane_rot = rotl64(lane_ff[0], 1);
         2'd1:    lane_rot = rotl64(lane_ff[1], 7);
         2'd2:    lane_rot = rotl64(lane_ff[2], 12);
         default: lane_rot = rotl64(lane_ff[3], 18);
      endcase
      op_mul    = is_mul_op(cmd.op);
      mul_start = cmd.go && op_mul && !busy_ff && !mul_done;

      mul_a = t_ff;
      mul_b = PRIME1;
      case (cmd.op)
         OP_LR_A: begin mul_a = stripe_sel; mul_b = PRIME2; end
         OP_MG_A: begin mul_a = lane_sel; mul_b = PRIME2; end
         OP_TW_A: begin mul_a = stripe_sel; mul_b = PRIME2; end
         OP_MG_C: begin mul_a = h_ff; mul_b = PRIME1; end
         OP_TW_C: begin mul_a = rotl64(h_ff, 27); mul_b = PRIME1; end
         OP_Q_A:  begin mul_a = {32'd0, word_ff[31:0]}; mul_b = PRIME1; end
         OP_Q_B:  begin mul_a = rotl64(h_ff, 23); mul_b = PRIME2; end
         OP_B_A:  begin mul_a = {56'd0, word_ff[{cmd.idx, 3'b000} +: 8]}; mul_b = PRIME5; end
         OP_B_B:  begin mul_a = rotl64(h_ff, 11); mul_b = PRIME1; end
         OP_F1:   begin mul_a = h_ff ^ (h_ff >> 33); mul_b = PRIME2; end
         OP_F2:   begin mul_a = h_ff ^ (h_ff >> 29); mul_b = PRIME3; end
         default: begin mul_a = t_ff; mul_b = PRIME1; end
      endcase

      word_in  = word_ff;
      last_in  = last_ff;
      full_in  = full_ff;
      n_in     = n_ff;
      total_in = total_ff;
      fill_in  = fill_ff;
      had_in   = had_ff;
      h_in     = h_ff;
      t_in     = t_ff;
      hash_in  = hash_ff;
      lane_in  = lane_ff;
      stripe_in = stripe_ff;
      busy_in  = mul_start ? 1'b1 : (mul_done ? 1'b0 : busy_ff);

      if (cmd.go) begin
         case (cmd.op)
            OP_LOAD: begin
               word_in = req_word;
               last_in = req_last;
               full_in = !req_last || (req_valid_bytes >= 4'd8);
               n_in    = (!req_last || (req_valid_bytes >= 4'd8)) ? 3'd0
                                                                  : req_valid_bytes[2:0];
            end
            OP_STORE: begin
               stripe_in[fill_ff] = word_ff;
               fill_in  = 2'(fill_ff + 2'd1);
               total_in = total_ff + 64'd8;
            end
            OP_STRIPE_END: begin
               fill_in  = 2'd0;
               had_in   = 1'b1;
               total_in = total_ff + 64'd8;
            end
            OP_H_INIT:  h_in = had_ff ? rotl64(lane_ff[0], 1) : PRIME5;
            OP_H_ROT:   h_in = h_ff + lane_rot;
            OP_ADD_LEN: h_in = h_ff + total_ff + {61'd0, n_ff};
            OP_OUT: begin
               hash_in    = h_ff ^ (h_ff >> 32);
               lane_in[0] = LANE0_INIT;
               lane_in[1] = LANE1_INIT;
               lane_in[2] = LANE2_INIT;
               lane_in[3] = LANE3_INIT;
               fill_in    = 2'd0;
               total_in   = 64'd0;
               had_in     = 1'b0;
            end
            default: begin
            end
         endcase
         if (mul_done) begin
            case (cmd.op)
               OP_LR_A:                   t_in = rotl64(lane_sel + mul_p, 31);
               OP_LR_B:                   lane_in[idx2] = mul_p;
               OP_MG_A, OP_TW_A:          t_in = rotl64(mul_p, 31);
               OP_MG_B, OP_TW_B:          h_in = h_ff ^ mul_p;
               OP_MG_C, OP_TW_C:          h_in = mul_p + PRIME4;
               OP_Q_A, OP_B_A:            h_in = h_ff ^ mul_p;
               OP_Q_B:                    h_in = mul_p + PRIME3;
               OP_B_B, OP_F1, OP_F2:      h_in = mul_p;
               default: begin
               end
            endcase
         end
      end

      st.done = cmd.go && (op_mul ? mul_done : 1'b1);
      st.last = last_ff;
      st.full = full_ff;
      st.had  = had_ff;
      st.fill = fill_ff;
      st.n    = n_ff;
   end

   always_ff @(posedge clock) begin
      word_ff   <= word_in;
      last_ff   <= last_in;
      full_ff   <= full_in;
      n_ff      <= n_in;
      h_ff      <= h_in;
      t_ff      <= t_in;
      hash_ff   <= hash_in;
      stripe_ff <= stripe_in;
      if (reset) begin
         lane_ff[0] <= LANE0_INIT;
         lane_ff[1] <= LANE1_INIT;
         lane_ff[2] <= LANE2_INIT;
         lane_ff[3] <= LANE3_INIT;
         total_ff   <= 64'd0;
         fill_ff    <= 2'd0;
         had_ff     <= 1'b0;
         busy_ff    <= 1'b0;
      end else begin
         lane_ff  <= lane_in;
         total_ff <= total_in;
         fill_ff  <= fill_in;
         had_ff   <= had_in;
         busy_ff  <= busy_in;
      end
   end

   assign rsp_hash = hash_ff;
endmodule

// ===== hw/rtl/xxh_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh_ctrl
// Sequencer: walks stripe rounds and the finishing steps, drives the handshakes.
// ----------------------------------------------------------------------------
module xxh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  xxh_pkg::status_type st,
   output xxh_pkg::cmd_type    cmd
);
   import xxh_pkg::*;

   state_type  state_ff, state_in;
   logic [2:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in, out_fire;
   logic [3:0] idx_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      idx_next  = {1'b0, idx_ff} + 4'd1;
      cmd.go    = 1'b0;
      cmd.op    = OP_NONE;
      cmd.idx   = idx_ff;
      req_ready = 1'b0;
      out_fire  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.op    = OP_LOAD;
            cmd.go    = req_valid;
            if (req_valid) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            idx_in = 3'd0;
            if (!st.full) begin
               state_in = ST_H_INIT;
            end else if (st.fill == 2'd3) begin
               state_in = ST_LR_A;
            end else begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.op = OP_STORE; cmd.go = 1'b1;
            state_in = st.last ? ST_H_INIT : ST_IDLE;
         end
         ST_LR_A: begin
            cmd.op = OP_LR_A; cmd.go = 1'b1;
            if (st.done) begin
               state_in = ST_LR_B;
            end
         end
         ST_LR_B: begin
            cmd.op = OP_LR_B; cmd.go = 1'b1;
            if (st.done) begin
               idx_in   = idx_next[2:0];
               state_in = (idx_ff == 3'd3) ? ST_STRIPE_END : ST_LR_A;
            end
         end
         ST_STRIPE_END: begin
            cmd.op = OP_STRIPE_END; cmd.go = 1'b1;
            state_in = st.last ? ST_H_INIT : ST_IDLE;
         end
         ST_H_INIT: begin
            cmd.op = OP_H_INIT; cmd.go = 1'b1;
            idx_in = 3'd1;
            state_in = st.had ? ST_H_ROT : ST_ADD_LEN;
         end
         ST_H_ROT: begin
            cmd.op = OP_H_ROT; cmd.go = 1'b1;
            idx_in = idx_next[2:0];
            if (idx_ff == 3'd3) begin
               idx_in   = 3'd0;
               state_in = ST_MG_A;
            end
         end
         ST_MG_A: begin
            cmd.op = OP_MG_A; cmd.go = 1'b1;
            if (st.done) state_in = ST_MG_B;
         end
         ST_MG_B: begin
            cmd.op = OP_MG_B; cmd.go = 1'b1;
            if (st.done) state_in = ST_MG_C;
         end
         ST_MG_C: begin
            cmd.op = OP_MG_C; cmd.go = 1'b1;
            if (st.done) begin
               idx_in   = idx_next[2:0];
               state_in = (idx_ff == 3'd3) ? ST_ADD_LEN : ST_MG_A;
            end
         end
         ST_ADD_LEN: begin
            cmd.op = OP_ADD_LEN; cmd.go = 1'b1;
            idx_in = 3'd0;
            if (st.fill != 2'd0)  state_in = ST_TW_A;
            else if (st.n >= 3'd4) state_in = ST_Q_A;
            else if (st.n != 3'd0) state_in = ST_B_A;
            else                   state_in = ST_F1;
         end
         ST_TW_A: begin
            cmd.op = OP_TW_A; cmd.go = 1'b1;
            if (st.done) state_in = ST_TW_B;
         end
         ST_TW_B: begin
            cmd.op = OP_TW_B; cmd.go = 1'b1;
            if (st.done) state_in = ST_TW_C;
         end
         ST_TW_C: begin
            cmd.op = OP_TW_C; cmd.go = 1'b1;
            if (st.done) begin
               idx_in = idx_next[2:0];
               if (idx_next != {2'd0, st.fill}) begin
                  state_in = ST_TW_A;
               end else begin
                  idx_in = 3'd0;
                  if (st.n >= 3'd4)      state_in = ST_Q_A;
                  else if (st.n != 3'd0) state_in = ST_B_A;
                  else                   state_in = ST_F1;
               end
            end
         end
         ST_Q_A: begin
            cmd.op = OP_Q_A; cmd.go = 1'b1;
            if (st.done) state_in = ST_Q_B;
         end
         ST_Q_B: begin
            cmd.op = OP_Q_B; cmd.go = 1'b1;
            if (st.done) begin
               idx_in   = 3'd4;
               state_in = (st.n > 3'd4) ? ST_B_A : ST_F1;
            end
         end
         ST_B_A: begin
            cmd.op = OP_B_A; cmd.go = 1'b1;
            if (st.done) state_in = ST_B_B;
         end
         ST_B_B: begin
            cmd.op = OP_B_B; cmd.go = 1'b1;
            if (st.done) begin
               idx_in   = idx_next[2:0];
               state_in = (idx_next == {1'b0, st.n}) ? ST_F1 : ST_B_A;
            end
         end
         ST_F1: begin
            cmd.op = OP_F1; cmd.go = 1'b1;
            if (st.done) state_in = ST_F2;
         end
         ST_F2: begin
            cmd.op = OP_F2; cmd.go = 1'b1;
            if (st.done) state_in = ST_OUT;
         end
         ST_OUT: begin
            // wait for the output register to be free
            cmd.op   = OP_OUT;
            out_fire = !rsp_valid_ff || rsp_ready;
            cmd.go   = out_fire;
            if (out_fire) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || out_fire;
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// ===== hw/rtl/xxh64_stream_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh64_stream_hash
// Streaming XXH64 (seed zero) over little-endian 64-bit message words.
// ----------------------------------------------------------------------------
// Feed the message one word per transfer, first byte in bits 7:0, and mark
// the final word with req_last; req_valid_bytes (0..8, larger saturates to 8)
// counts the valid bytes of that final word only, and an empty message is a
// single last transfer with zero valid bytes. One rsp_hash transfer follows
// each last word. All 64-bit multiplies share one unit built on a single
// 32x32 multiplier, and that unit sets the pace. A word that closes a
// 32-byte stripe runs four lane rounds of two products each; a word that
// does not close a stripe is only buffered. The end of a message runs hash
// start, a merge of the lanes if a stripe was seen, length, one round per
// buffered full word, a 4-byte tail step, one step per remaining tail byte,
// two avalanche products and output. The result sits in an output
// register, so a new message may start while the last hash waits; a second
// hash waits in the sequencer until the first one leaves.
module xxh64_stream_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_word,
   input  logic [3:0]  req_valid_bytes,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_hash
);
   import xxh_pkg::*;

   cmd_type    cmd;
   status_type st;

   // sequencer: one datapath step at a time
   xxh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .st        (st),
      .cmd       (cmd)
   );

   // lanes, stripe buffer, running hash and output register
   xxh_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_word        (req_word),
      .req_valid_bytes (req_valid_bytes),
      .req_last        (req_last),
      .cmd             (cmd),
      .st              (st),
      .rsp_hash        (rsp_hash)
   );
endmodule
